// File: design/pwmca_pkg.sv
// ----------------------------------------------------------------------------
// pwmca_pkg
// shared types and constants of the pwm channel allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pwmca_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int CNT_W        = 5;

    localparam int PIN_W   = 7;
    localparam int FREQ_W  = 26;
    localparam int BITS_W  = 5;
    localparam int FRAC_W  = 17;
    localparam int DUTYIN_W = 18;
    localparam int DUTY_W  = 20;
    localparam int CHAN_W  = 4;

    localparam logic [BITS_W-1:0] MAX_RES_BITS = 5'd20;
    localparam logic [FRAC_W-1:0] Q16_ONE      = 17'h10000;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_RELALL  = 2'd2,
        CMD_WRITE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_SETUP  = 3'd1,
        ACT_DETACH = 3'd2,
        ACT_DUTY   = 3'd3,
        ACT_OOC    = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// File: design/pwm_channel_allocator_unit.sv
// ----------------------------------------------------------------------------
// pwm_channel_allocator_unit
// first-free pwm channel slot allocator with release, release-all and duty
// ----------------------------------------------------------------------------
//  channel | dir | tdata / tuser                          | tlast
//  s_*     | in  | pin, freq, bits, duty / cmd            | -
//  m_*     | out | channel, pin, freq, bits, duty / action| last result of item
//
//  slots are scanned one at a time through a single-port slot memory with a
//  registered read, each slot visited passing through a read state and a check state
//  allocate, release, write: the scan stops at the first hit, or runs over every slot on a miss
//  release-all scans every slot; a negative pin skips the scan and goes to the final result
//  used flags sit in flops cleared by reset, so no clearing pass is needed
//  a full output register stalls the scan; s_tready is high only between items
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_channel_allocator_unit
#(
    parameter int CHANNELS = pwmca_pkg::CHANNELS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // pin_number, freq_hz, resolution_bits, duty_fraction
    input  wire logic [1:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // channel, pin_out, freq_out, bits_out, duty_value
    output logic [2:0]       m_tuser,   // action
    output logic             m_tlast
);

    localparam int IdxW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IdxExtW = (IdxW > pwmca_pkg::CHAN_W) ? IdxW : pwmca_pkg::CHAN_W;
    localparam int MemW    = pwmca_pkg::PIN_W + pwmca_pkg::BITS_W;
    localparam logic [IdxW-1:0] IdxLast = IdxW'(CHANNELS - 1);

    pwmca_pkg::state_t state_reg, state_next;
    pwmca_pkg::cmd_t   cmd_reg, cmd_next;
    logic                                neg_reg, neg_next;
    logic [pwmca_pkg::PIN_W-1:0]         pin_reg, pin_next;
    logic [pwmca_pkg::FREQ_W-1:0]        freq_reg, freq_next;
    logic [pwmca_pkg::BITS_W-1:0]        bits_reg, bits_next;
    logic [pwmca_pkg::DUTYIN_W-1:0]      duty_reg, duty_next;
    logic [IdxW-1:0]                     idx_reg, idx_next;
    logic [CHANNELS-1:0]                 used_reg, used_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic [pwmca_pkg::CHAN_W-1:0]        pend_chan_reg, pend_chan_next;
    logic [pwmca_pkg::PIN_W-1:0]         pend_pin_reg, pend_pin_next;
    logic [pwmca_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    logic                                out_valid_reg, out_valid_next;
    pwmca_pkg::action_t                  out_action_reg, out_action_next;
    logic [pwmca_pkg::CHAN_W-1:0]        out_chan_reg, out_chan_next;
    logic [pwmca_pkg::PIN_W-1:0]         out_pin_reg, out_pin_next;
    logic [pwmca_pkg::FREQ_W-1:0]        out_freq_reg, out_freq_next;
    logic [pwmca_pkg::BITS_W-1:0]        out_bits_reg, out_bits_next;
    logic [pwmca_pkg::DUTY_W-1:0]        out_duty_reg, out_duty_next;
    logic                                out_last_reg, out_last_next;

    logic [MemW-1:0] slot_mem [CHANNELS];
    logic [MemW-1:0] rd_data_reg;
    logic            mem_we;

    logic                         push;
    logic                         can_push;
    logic                         step;
    logic                         cur_used;
    logic                         pin_hit;
    logic [pwmca_pkg::PIN_W-1:0]  rd_pin;
    logic [pwmca_pkg::BITS_W-1:0] rd_bits;
    logic [IdxExtW-1:0]           idx_ext;
    logic [pwmca_pkg::CHAN_W-1:0] cur_chan;
    logic [pwmca_pkg::DUTY_W-1:0] duty_calc;
    logic [pwmca_pkg::BITS_W-1:0] in_bits;
    pwmca_pkg::action_t           p_action;
    logic [pwmca_pkg::CHAN_W-1:0] p_chan;
    logic [pwmca_pkg::PIN_W-1:0]  p_pin;
    logic [pwmca_pkg::FREQ_W-1:0] p_freq;
    logic [pwmca_pkg::BITS_W-1:0] p_bits;
    logic [pwmca_pkg::DUTY_W-1:0] p_duty;
    logic                         p_last;

    assign rd_pin   = rd_data_reg[MemW-1:pwmca_pkg::BITS_W];
    assign rd_bits  = rd_data_reg[pwmca_pkg::BITS_W-1:0];
    assign cur_used = used_reg[idx_reg];
    assign pin_hit  = cur_used && (rd_pin == pin_reg);
    assign idx_ext  = IdxExtW'(idx_reg);
    assign cur_chan = idx_ext[pwmca_pkg::CHAN_W-1:0];
    assign can_push = !out_valid_reg || m_tready;
    assign in_bits  = (s_tdata[38:34] > pwmca_pkg::MAX_RES_BITS) ?
                      pwmca_pkg::MAX_RES_BITS : s_tdata[38:34];

    pwmca_duty_scale u_duty
    (
        .duty_fraction (duty_reg),
        .bits          (rd_bits),
        .duty_value    (duty_calc)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        neg_next        = neg_reg;
        pin_next        = pin_reg;
        freq_next       = freq_reg;
        bits_next       = bits_reg;
        duty_next       = duty_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        pend_valid_next = pend_valid_reg;
        pend_chan_next  = pend_chan_reg;
        pend_pin_next   = pend_pin_reg;
        cnt_next        = cnt_reg;
        mem_we          = 1'b0;
        push            = 1'b0;
        step            = 1'b0;
        p_action        = pwmca_pkg::ACT_NONE;
        p_chan          = '0;
        p_pin           = '0;
        p_freq          = '0;
        p_bits          = '0;
        p_duty          = '0;
        p_last          = 1'b1;

        case (state_reg)
            pwmca_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next        = pwmca_pkg::cmd_t'(s_tuser);
                    neg_next        = s_tdata[7];
                    pin_next        = s_tdata[6:0];
                    freq_next       = s_tdata[33:8];
                    bits_next       = in_bits;
                    duty_next       = s_tdata[56:39];
                    idx_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    if (s_tuser != pwmca_pkg::CMD_RELALL && s_tdata[7])
                    begin
                        state_next = pwmca_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = pwmca_pkg::ST_READ;
                    end
                end
            end

            pwmca_pkg::ST_READ:
            begin
                state_next = pwmca_pkg::ST_CHECK;
            end

            pwmca_pkg::ST_CHECK:
            begin
                case (cmd_reg)
                    pwmca_pkg::CMD_ALLOC:
                    begin
                        if (!cur_used)
                        begin
                            push     = 1'b1;
                            p_action = pwmca_pkg::ACT_SETUP;
                            p_chan   = cur_chan;
                            p_pin    = pin_reg;
                            p_freq   = freq_reg;
                            p_bits   = bits_reg;
                            if (can_push)
                            begin
                                mem_we             = 1'b1;
                                used_next[idx_reg] = 1'b1;
                                state_next         = pwmca_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                    pwmca_pkg::CMD_RELEASE:
                    begin
                        if (pin_hit)
                        begin
                            push     = 1'b1;
                            p_action = pwmca_pkg::ACT_DETACH;
                            p_chan   = cur_chan;
                            p_pin    = pin_reg;
                            if (can_push)
                            begin
                                used_next[idx_reg] = 1'b0;
                                state_next         = pwmca_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                    pwmca_pkg::CMD_WRITE:
                    begin
                        if (pin_hit)
                        begin
                            push     = 1'b1;
                            p_action = pwmca_pkg::ACT_DUTY;
                            p_chan   = cur_chan;
                            p_pin    = pin_reg;
                            p_duty   = duty_calc;
                            if (can_push)
                            begin
                                state_next = pwmca_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                    pwmca_pkg::CMD_RELALL:
                    begin
                        // one detach is held back so the final one can carry last
                        if (cur_used && cnt_reg < pwmca_pkg::CNT_W'(pwmca_pkg::MAX_RESULTS)
                            && pend_valid_reg)
                        begin
                            push     = 1'b1;
                            p_action = pwmca_pkg::ACT_DETACH;
                            p_chan   = pend_chan_reg;
                            p_pin    = pend_pin_reg;
                            p_last   = 1'b0;
                        end
                        if (!push || can_push)
                        begin
                            step = 1'b1;
                            if (cur_used)
                            begin
                                used_next[idx_reg] = 1'b0;
                                if (cnt_reg < pwmca_pkg::CNT_W'(pwmca_pkg::MAX_RESULTS))
                                begin
                                    pend_valid_next = 1'b1;
                                    pend_chan_next  = cur_chan;
                                    pend_pin_next   = rd_pin;
                                    cnt_next        = cnt_reg + 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = pwmca_pkg::ST_IDLE;
                    end
                endcase

                if (step)
                begin
                    if (idx_reg == IdxLast)
                    begin
                        state_next = pwmca_pkg::ST_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = pwmca_pkg::ST_READ;
                    end
                end
            end

            pwmca_pkg::ST_FIN:
            begin
                push = 1'b1;
                if (cmd_reg == pwmca_pkg::CMD_RELALL)
                begin
                    if (pend_valid_reg)
                    begin
                        p_action = pwmca_pkg::ACT_DETACH;
                        p_chan   = pend_chan_reg;
                        p_pin    = pend_pin_reg;
                    end
                end
                else if (!neg_reg && cmd_reg == pwmca_pkg::CMD_ALLOC)
                begin
                    p_action = pwmca_pkg::ACT_OOC;
                    p_pin    = pin_reg;
                end
                if (can_push)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = pwmca_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pwmca_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_chan_next   = out_chan_reg;
        out_pin_next    = out_pin_reg;
        out_freq_next   = out_freq_reg;
        out_bits_next   = out_bits_reg;
        out_duty_next   = out_duty_reg;
        out_last_next   = out_last_reg;
        if (push && can_push)
        begin
            out_valid_next  = 1'b1;
            out_action_next = p_action;
            out_chan_next   = p_chan;
            out_pin_next    = p_pin;
            out_freq_next   = p_freq;
            out_bits_next   = p_bits;
            out_duty_next   = p_duty;
            out_last_next   = p_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pwmca_pkg::ST_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        neg_reg        <= neg_next;
        pin_reg        <= pin_next;
        freq_reg       <= freq_next;
        bits_reg       <= bits_next;
        duty_reg       <= duty_next;
        idx_reg        <= idx_next;
        pend_chan_reg  <= pend_chan_next;
        pend_pin_reg   <= pend_pin_next;
        out_action_reg <= out_action_next;
        out_chan_reg   <= out_chan_next;
        out_pin_reg    <= out_pin_next;
        out_freq_reg   <= out_freq_next;
        out_bits_reg   <= out_bits_next;
        out_duty_reg   <= out_duty_next;
        out_last_reg   <= out_last_next;
    end

    // slot memory: pin and resolution per slot, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[idx_reg] <= {pin_reg, bits_reg};
        end
        if (state_reg == pwmca_pkg::ST_READ)
        begin
            rd_data_reg <= slot_mem[idx_reg];
        end
    end

    assign s_tready = (state_reg == pwmca_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_duty_reg, out_bits_reg, out_freq_reg,
                       out_pin_reg, out_chan_reg};

`ifndef SYNTH
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pwmca_pkg::ST_IDLE |-> !pend_valid_reg)
        else $error("held detach left over after item");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pwmca_pkg::CNT_W'(pwmca_pkg::MAX_RESULTS))
        else $error("detach count past result limit");

    a_alloc_takes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (push && can_push && p_action == pwmca_pkg::ACT_SETUP)
        |=> $countones(used_reg) == $past($countones(used_reg)) + 1)
        else $error("setup result without a slot taken");

    a_fin_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pwmca_pkg::ST_FIN && can_push) |=> state_reg == pwmca_pkg::ST_IDLE)
        else $error("final result not issued");
`endif

endmodule

`default_nettype wire

// File: design/pwmca_duty_scale.sv
// ----------------------------------------------------------------------------
// pwmca_duty_scale
// clamps a signed q16 duty fraction to 0..1 and scales it by 2^bits-1
// ----------------------------------------------------------------------------
`default_nettype none

module pwmca_duty_scale
(
    input  wire logic [pwmca_pkg::DUTYIN_W-1:0] duty_fraction,
    input  wire logic [pwmca_pkg::BITS_W-1:0]   bits,
    output logic      [pwmca_pkg::DUTY_W-1:0]   duty_value
);

    localparam int ProdW = pwmca_pkg::FRAC_W + pwmca_pkg::DUTY_W;

    logic [pwmca_pkg::FRAC_W-1:0] frac;
    logic [pwmca_pkg::BITS_W-1:0] bits_sat;
    logic [ProdW-1:0]             frac_ext;
    logic [ProdW-1:0]             prod;

    always_comb
    begin
        if (duty_fraction[pwmca_pkg::DUTYIN_W-1])
        begin
            frac = '0;
        end
        else if (duty_fraction[pwmca_pkg::FRAC_W-1:0] > pwmca_pkg::Q16_ONE)
        begin
            frac = pwmca_pkg::Q16_ONE;
        end
        else
        begin
            frac = duty_fraction[pwmca_pkg::FRAC_W-1:0];
        end
        bits_sat = (bits > pwmca_pkg::MAX_RES_BITS) ? pwmca_pkg::MAX_RES_BITS : bits;
    end

    // frac * (2^b - 1) as a shift and one subtract
    assign frac_ext   = ProdW'(frac);
    assign prod       = (frac_ext << bits_sat) - frac_ext;
    assign duty_value = prod[pwmca_pkg::DUTY_W+15:16];

endmodule

`default_nettype wire
